[hw/rtl/decimal_ascii_to_int64_parser_macros.svh]
// ----------------------------------------------------------------------------
// Decimal parser assertion macros
// Concurrent assertion wrappers shared by the parser RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ASCII_TO_INT64_PARSER_MACROS_SVH
`define DECIMAL_ASCII_TO_INT64_PARSER_MACROS_SVH

`ifndef SYNTHESIS

`define DAI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DAI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DAI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define DAI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/dai_pkg.sv]
// ----------------------------------------------------------------------------
// Decimal parser package
// Beat types, character codes and parse phases shared by the parser modules.
// ----------------------------------------------------------------------------
package dai_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int RESULT_WIDTH    = 64;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } in_beat_t;

    typedef struct packed {
        logic                           parse_ok;
        logic signed [RESULT_WIDTH-1:0] parsed_value;
    } out_beat_t;

endpackage

[hw/rtl/decimal_ascii_to_int64_parser.sv]
// ----------------------------------------------------------------------------
// Decimal ASCII to int64 parser
// Streams a decimal string one character per beat and returns a signed value.
// ----------------------------------------------------------------------------
// One character beat is taken per clock cycle while the input is not stalled.
// A beat is captured in the input register when it is accepted, and the parse
// core applies it to the state when the input register hands it on; in that
// same cycle the beat that ends a string writes one result beat into the
// output register. The state loop (a shift-add by ten and one compare) is
// combinational from the state registers back to them, which sets the rate
// of one character per cycle. Input stalls only when a final character
// meets a full result register that is itself stalled.
module decimal_ascii_to_int64_parser #(
    parameter int VALUE_WIDTH = dai_pkg::VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  dai_pkg::in_beat_t  char_beat,
    output logic               result_valid,
    input  logic               result_stall,
    output dai_pkg::out_beat_t result_beat
);
    import dai_pkg::*;

    logic      held_valid;
    in_beat_t  held_beat;
    logic      take;
    logic      load;
    out_beat_t res;

    assign take = held_valid && (!held_beat.last_char || !result_valid || !result_stall);
    assign load = take && held_beat.last_char;

    dai_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (char_valid),
        .stall      (char_stall),
        .beat       (char_beat),
        .take       (take),
        .held_valid (held_valid),
        .held_beat  (held_beat)
    );

    dai_parse_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (take),
        .beat  (held_beat),
        .res   (res)
    );

    dai_out_reg u_out_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .res   (res),
        .valid (result_valid),
        .stall (result_stall),
        .beat  (result_beat)
    );

endmodule

[hw/rtl/dai_in_reg.sv]
// ----------------------------------------------------------------------------
// Decimal parser input register
// Holds one character beat until the parse core consumes it.
// ----------------------------------------------------------------------------
module dai_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  dai_pkg::in_beat_t beat,
    input  logic              take,
    output logic              held_valid,
    output dai_pkg::in_beat_t held_beat
);
    import dai_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    assign stall      = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (valid && !stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && !stall)
        begin
            beat_reg <= beat;
        end
    end

endmodule

[hw/rtl/dai_parse_core.sv]
// ----------------------------------------------------------------------------
// Decimal parser core
// Holds the parse state and applies one character per cycle to it when stepped.
// ----------------------------------------------------------------------------
module dai_parse_core #(
    parameter int VALUE_WIDTH = dai_pkg::VALUE_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  dai_pkg::in_beat_t  beat,
    output dai_pkg::out_beat_t res
);
    import dai_pkg::*;

    `include "decimal_ascii_to_int64_parser_macros.svh"

    localparam int WW = VALUE_WIDTH + 4;
    localparam logic [VALUE_WIDTH-1:0] LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic                   neg_reg;
    logic                   neg_next;
    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic                   fail_reg;
    logic                   fail_next;
    logic                   lz_reg;
    logic                   lz_next;

    logic                   is_digit;
    logic                   is_lead;
    logic [3:0]             dig;
    logic [WW-1:0]          prod;
    logic                   ovf;
    logic                   ok;
    logic [VALUE_WIDTH-1:0] val_w;

    always_comb
    begin
        is_digit = (beat.char_in >= CH_ZERO) && (beat.char_in <= CH_NINE);
        is_lead  = (beat.char_in >= CH_ONE) && (beat.char_in <= CH_NINE);
        dig      = beat.char_in[3:0];
        prod     = (WW'(mag_reg) << 3) + (WW'(mag_reg) << 1) + WW'(dig);
        ovf      = prod > WW'(LIMIT);

        mag_next   = mag_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        fail_next  = fail_reg;
        lz_next    = lz_reg;

        if (!fail_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (beat.char_in == CH_ZERO)
                    begin
                        lz_next    = 1'b1;
                        phase_next = PH_DIGIT;
                    end
                    else if (beat.char_in == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (is_lead)
                    begin
                        mag_next   = VALUE_WIDTH'(dig);
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (is_lead)
                    begin
                        mag_next   = VALUE_WIDTH'(dig);
                        phase_next = PH_DIGIT;
                    end
                    else
                    begin
                        fail_next = 1'b1;
                    end
                end
                default:
                begin
                    if (lz_reg || !is_digit || ovf)
                    begin
                        fail_next = 1'b1;
                    end
                    else
                    begin
                        mag_next = prod[VALUE_WIDTH-1:0];
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        ok    = 1'b0;
        val_w = '0;
        if (!fail_next && phase_next != PH_START && phase_next != PH_SIGN)
        begin
            if (lz_next)
            begin
                ok = 1'b1;
            end
            else if (neg_next)
            begin
                ok    = 1'b1;
                val_w = ~mag_next + VALUE_WIDTH'(1);
            end
            else if (!mag_next[VALUE_WIDTH-1])
            begin
                ok    = 1'b1;
                val_w = mag_next;
            end
        end
        res.parse_ok     = ok;
        res.parsed_value = RESULT_WIDTH'($signed(val_w));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            phase_reg <= PH_START;
            fail_reg  <= 1'b0;
            lz_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (beat.last_char)
            begin
                mag_reg   <= '0;
                neg_reg   <= 1'b0;
                phase_reg <= PH_START;
                fail_reg  <= 1'b0;
                lz_reg    <= 1'b0;
            end
            else
            begin
                mag_reg   <= mag_next;
                neg_reg   <= neg_next;
                phase_reg <= phase_next;
                fail_reg  <= fail_next;
                lz_reg    <= lz_next;
            end
        end
    end

    `DAI_ASSERT_IMP(a_mag_bound, clk, rst_n, 1'b1, mag_reg <= LIMIT)
    `DAI_ASSERT_IMP(a_lz_mag, clk, rst_n, lz_reg, mag_reg == '0 && phase_reg == PH_DIGIT)
    `DAI_ASSERT_NXT(a_clear, clk, rst_n, step && beat.last_char,
        phase_reg == PH_START && mag_reg == '0 && !fail_reg && !neg_reg && !lz_reg)

endmodule

[hw/rtl/dai_out_reg.sv]
// ----------------------------------------------------------------------------
// Decimal parser result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module dai_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  dai_pkg::out_beat_t res,
    output logic               valid,
    input  logic               stall,
    output dai_pkg::out_beat_t beat
);
    import dai_pkg::*;

    `include "decimal_ascii_to_int64_parser_macros.svh"

    logic      valid_reg;
    out_beat_t beat_reg;

    assign valid = valid_reg;
    assign beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= res;
        end
    end

    `DAI_ASSERT_IMP(a_no_overwrite, clk, rst_n, load, !valid_reg || !stall)
    `DAI_ASSERT_IMP(a_fail_zero, clk, rst_n, valid_reg && !beat_reg.parse_ok,
        beat_reg.parsed_value == '0)
    `DAI_ASSERT_NXT(a_load_shows, clk, rst_n, load, valid_reg)

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Decimal ASCII to int64 parser testbench
// Streams decimal strings one character beat at a time, with random idle and
// stall on both sides and a long result-side hold, and checks each result
// beat against a typed answer for known directed strings, else against an
// in-bench parser that tracks the same magnitude, sign and phase state.
// ----------------------------------------------------------------------------
module tb_top;

    import dai_pkg::*;

    localparam int          VALUE_WIDTH  = VALUE_WIDTH_DEF;
    localparam logic [63:0] MAG_LIMIT    = 64'd1 << (VALUE_WIDTH - 1);
    localparam logic [63:0] RADIX        = 64'd10;
    localparam int          BEAT_TARGET  = 950;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          PRINT_CAP    = 100;
    localparam int          N_DIRECTED   = 20;

    typedef logic [7:0] text_q_t [$];

    typedef struct {
        string  text;
        bit     known;
        bit     ok;
        longint value;
    } dir_row_t;

    typedef struct {
        bit     known;
        bit     ok;
        longint value;
    } typed_answer_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      char_valid   = 1'b0;
    logic      char_stall;
    in_beat_t  char_beat    = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_beat_t result_beat;

    logic [63:0] acc_mag   = '0;
    logic        acc_neg   = 1'b0;
    phase_t      acc_phase = PH_START;
    logic        acc_bad   = 1'b0;
    logic        acc_zero  = 1'b0;

    out_beat_t     pending_results [$];
    typed_answer_t typed_answers [$];

    int  cycle_count        = 0;
    int  mismatch_count     = 0;
    int  beats_sent         = 0;
    int  strings_sent       = 0;
    int  results_seen       = 0;
    int  valid_results      = 0;
    int  input_stall_cycles = 0;
    bit  calm               = 1'b0;
    bit  hold_request       = 1'b0;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{"0",                    1'b1, 1'b1, 0},
        '{"7",                    1'b1, 1'b1, 7},
        '{"-1",                   1'b1, 1'b1, -1},
        '{"9223372036854775807",  1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF},
        '{"-9223372036854775808", 1'b1, 1'b1, 64'h8000_0000_0000_0000},
        '{"9223372036854775808",  1'b1, 1'b0, 0},
        '{"-9223372036854775809", 1'b1, 1'b0, 0},
        '{"18446744073709551616", 1'b1, 1'b0, 0},
        '{"-0",                   1'b1, 1'b0, 0},
        '{"00",                   1'b1, 1'b0, 0},
        '{"05",                   1'b1, 1'b0, 0},
        '{"-",                    1'b1, 1'b0, 0},
        '{"+5",                   1'b1, 1'b0, 0},
        '{"1a99",                 1'b1, 1'b0, 0},
        '{"--3",                  1'b1, 1'b0, 0},
        '{"\377",                 1'b1, 1'b0, 0},
        '{"4\2603",               1'b1, 1'b0, 0},
        '{"1:/",                  1'b1, 1'b0, 0},
        '{"1234567890",           1'b0, 1'b0, 0},
        '{"-42",                  1'b0, 1'b0, 0}
    };

    decimal_ascii_to_int64_parser #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_beat    (char_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Applies one character to the parse state; returns 1 when a result is due.
    function automatic bit apply_char(input in_beat_t beat, output out_beat_t res);
        logic [7:0]  c;
        logic [63:0] d;
        bit          is_digit;
        bit          is_lead;
        c        = beat.char_in;
        d        = {60'd0, c[3:0]};
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_lead  = (c >= CH_ONE) && (c <= CH_NINE);
        res      = '0;
        if (!acc_bad)
        begin
            case (acc_phase)
                PH_START:
                begin
                    if (c == CH_ZERO)
                    begin
                        acc_zero  = 1'b1;
                        acc_phase = PH_DIGIT;
                    end
                    else if (c == CH_MINUS)
                    begin
                        acc_neg   = 1'b1;
                        acc_phase = PH_SIGN;
                    end
                    else if (is_lead)
                    begin
                        acc_mag   = d;
                        acc_phase = PH_DIGIT;
                    end
                    else
                    begin
                        acc_bad = 1'b1;
                    end
                end
                PH_SIGN:
                begin
                    if (is_lead)
                    begin
                        acc_mag   = d;
                        acc_phase = PH_DIGIT;
                    end
                    else
                    begin
                        acc_bad = 1'b1;
                    end
                end
                default:
                begin
                    if (acc_zero || !is_digit)
                        acc_bad = 1'b1;
                    else if (acc_mag > (MAG_LIMIT - d) / RADIX)
                        acc_bad = 1'b1;
                    else
                        acc_mag = acc_mag * RADIX + d;
                end
            endcase
        end
        if (!beat.last_char)
            return 1'b0;
        if (!acc_bad && acc_phase != PH_SIGN && acc_phase != PH_START)
        begin
            if (acc_zero)
            begin
                res.parse_ok = 1'b1;
            end
            else if (acc_neg)
            begin
                res.parse_ok     = 1'b1;
                res.parsed_value = 64'd0 - acc_mag;
            end
            else if (acc_mag <= MAG_LIMIT - 64'd1)
            begin
                res.parse_ok     = 1'b1;
                res.parsed_value = acc_mag;
            end
        end
        acc_mag   = '0;
        acc_neg   = 1'b0;
        acc_phase = PH_START;
        acc_bad   = 1'b0;
        acc_zero  = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void append_digits(ref text_q_t txt, input int unsigned count,
                                          input bit lead);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0 && lead)
                txt.push_back(CH_ONE + 8'($urandom_range(8)));
            else
                txt.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    function automatic text_q_t random_text();
        text_q_t     txt;
        string       limit_head;
        int unsigned pick;
        int unsigned pos;
        txt        = {};
        limit_head = "922337203685477580";
        pick       = $urandom_range(99);
        if (pick < 12)
        begin
            if ($urandom_range(1) != 0)
                txt.push_back(CH_MINUS);
            for (int i = 0; i < limit_head.len(); i++)
                txt.push_back(limit_head[i]);
            append_digits(txt, ($urandom_range(3) == 0) ? 2 : 1, 1'b0);
        end
        else if (pick < 55)
        begin
            if ($urandom_range(9) < 4)
                txt.push_back(CH_MINUS);
            append_digits(txt, ($urandom_range(2) != 0) ? $urandom_range(6, 1)
                                                         : $urandom_range(20, 7), 1'b1);
        end
        else if (pick < 60)
        begin
            txt.push_back(CH_ZERO);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(3))
                0:
                begin
                    txt.push_back(CH_MINUS);
                    if ($urandom_range(1) != 0)
                    begin
                        txt.push_back(CH_ZERO);
                        append_digits(txt, $urandom_range(3), 1'b0);
                    end
                end
                1:
                begin
                    txt.push_back(CH_ZERO);
                    append_digits(txt, $urandom_range(5, 1), 1'b0);
                end
                default:
                begin
                    if ($urandom_range(1) != 0)
                        txt.push_back(CH_MINUS);
                    append_digits(txt, $urandom_range(8, 1), 1'b1);
                    pos      = $urandom_range(txt.size() - 1);
                    txt[pos] = 8'($urandom_range(255));
                end
            endcase
        end
        else
        begin
            for (int i = 0; i < $urandom_range(6, 1); i++)
            begin
                if ($urandom_range(1) != 0)
                    txt.push_back(8'($urandom_range(255)));
                else if ($urandom_range(3) == 0)
                    txt.push_back(CH_MINUS);
                else
                    txt.push_back(CH_ZERO + 8'($urandom_range(9)));
            end
        end
        return txt;
    endfunction

    task automatic put_char(input logic [7:0] c, input logic fin);
        char_beat  <= '{char_in: c, last_char: fin};
        char_valid <= 1'b1;
        do
            @(posedge clk);
        while (char_stall);
        beats_sent++;
        if (!calm && $urandom_range(99) < 13)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_text(input text_q_t txt, input bit known, input bit ok,
                             input longint value);
        typed_answers.push_back('{known, ok, value});
        foreach (txt[i])
            put_char(txt[i], i == txt.size() - 1);
        strings_sent++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin : result_check
        out_beat_t     got;
        out_beat_t     want;
        typed_answer_t note;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = result_beat;
                results_seen++;
                if (got.parse_ok === 1'b1)
                    valid_results++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.parse_ok !== want.parse_ok)
                        report_mismatch($sformatf("result %0d parse_ok %b, expected %b",
                                                  results_seen, got.parse_ok, want.parse_ok));
                    if (got.parsed_value !== want.parsed_value)
                        report_mismatch($sformatf("result %0d parsed_value %0d, expected %0d",
                                                  results_seen, got.parsed_value,
                                                  want.parsed_value));
                end
            end
            if (char_valid && char_stall)
                input_stall_cycles++;
            if (char_valid && !char_stall && apply_char(char_beat, want))
            begin
                note = typed_answers.pop_front();
                if (note.known)
                begin
                    want.parse_ok     = note.ok;
                    want.parsed_value = note.value;
                end
                pending_results.push_back(want);
            end
        end
    end

    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            result_stall <= !calm && ($urandom_range(99) < 13);
        end
    end

    initial
    begin
        text_q_t txt;
        int      string_index;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            txt = {};
            for (int k = 0; k < dir_rows[r].text.len(); k++)
                txt.push_back(dir_rows[r].text[k]);
            send_text(txt, dir_rows[r].known, dir_rows[r].ok, dir_rows[r].value);
        end

        string_index = 0;
        while (beats_sent < BEAT_TARGET)
        begin
            if (string_index == 8)
                hold_request = 1'b1;
            if (string_index == 30)
            begin
                char_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            calm = (string_index >= 50) && (string_index < 66);
            send_text(random_text(), 1'b0, 1'b0, 0);
            string_index++;
        end
        char_valid <= 1'b0;

        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));

        $display("Sent %0d character beats in %0d strings; checked %0d results, %0d valid.",
                 beats_sent, strings_sent, results_seen, valid_results);
        $display("The input was held off for %0d cycles by result-side back-pressure.",
                 input_stall_cycles);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[decimal_ascii_to_int64_parser.f]
+incdir+hw/rtl
hw/rtl/dai_pkg.sv
hw/rtl/dai_in_reg.sv
hw/rtl/dai_parse_core.sv
hw/rtl/dai_out_reg.sv
hw/rtl/decimal_ascii_to_int64_parser.sv
bench/tb_top.sv
